FILE: rtl/rtcr_pkg.sv
// Shared types, constants and helper functions for the tag capture and replay unit.
// Used by every module under rtl/; depends on nothing else.
package rtcr_pkg;

    // Group and frame geometry
    localparam int GROUP_LEN  = 14;
    localparam int TAG_DIGITS = 10;
    localparam int TAG_W      = 40;
    localparam int DIGIT_W    = 8;
    localparam int NIB_W      = 4;
    localparam int IDX_W      = 6;
    localparam int POS_W      = 4;
    localparam int OUT_DATA_W = 56;

    // Byte positions within a capture group
    localparam logic [POS_W-1:0] POS_FIRST     = 4'd0;
    localparam logic [POS_W-1:0] POS_DATA_LAST = 4'd10;
    localparam logic [POS_W-1:0] POS_CHK_ODD   = 4'd11;
    localparam logic [POS_W-1:0] POS_CHK_EVEN  = 4'd12;
    localparam logic [POS_W-1:0] POS_LAST      = 4'd13;

    // Copy sweep length (one read ahead of the write)
    localparam logic [POS_W-1:0] COPY_END      = 4'd10;
    localparam logic [POS_W-1:0] DIGIT_LAST    = 4'd9;

    // Frame bit positions
    localparam logic [IDX_W-1:0] BIT_PRE_LAST   = 6'd8;
    localparam logic [IDX_W-1:0] BIT_DATA_START = 6'd9;
    localparam logic [IDX_W-1:0] BIT_COL_START  = 6'd59;
    localparam logic [IDX_W-1:0] BIT_STOP       = 6'd63;
    localparam logic [2:0]       SUB_PARITY     = 3'd4;

    // ASCII conversion
    localparam logic [7:0] ASCII_ZERO   = 8'd48;
    localparam logic [7:0] ASCII_NINE   = 8'd57;
    localparam logic [7:0] ALPHA_OFFSET = 8'd55;

    // Input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_SEND = 1'b1;

    // Result kind codes
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BIT    = 1'b1;

    // Capture status codes
    localparam logic [1:0] STATUS_CK_FAIL = 2'd0;
    localparam logic [1:0] STATUS_SAME    = 2'd1;
    localparam logic [1:0] STATUS_NEW     = 2'd2;

    // Control sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_COPY = 5'b00100,
        S_STAT = 5'b01000,
        S_SEND = 5'b10000
    } t_state;

    // Access request to a digit memory
    typedef struct packed {
        logic               rd_en;
        logic [POS_W-1:0]   rd_addr;
        logic               wr_en;
        logic [POS_W-1:0]   wr_addr;
        logic [DIGIT_W-1:0] wr_data;
    } t_mem_req;

    // One result beat handed to the output stage
    typedef struct packed {
        logic             kind;
        logic [1:0]       status;
        logic [TAG_W-1:0] tag_value;
        logic [IDX_W-1:0] bit_index;
        logic             frame_bit;
        logic             last;
    } t_out_beat;

    // Map an ASCII byte to its digit value, modulo 256
    function automatic logic [DIGIT_W-1:0] to_digit(input logic [7:0] b);
        logic [DIGIT_W-1:0] d;
        if (b inside {[ASCII_ZERO:ASCII_NINE]}) begin
            d = b - ASCII_ZERO;
        end else begin
            d = b - ALPHA_OFFSET;
        end
        return d;
    endfunction

endpackage

FILE: rtl/rtcr_digit_ram.sv
// Capture digit memory: one group of converted reader bytes.
// Single write port, one registered read port. Depends on rtcr_pkg.
module rtcr_digit_ram
    import rtcr_pkg::*;
(
    input  logic               i_clk,
    input  t_mem_req           i_req,
    output logic [DIGIT_W-1:0] o_rd_data
);

    logic [DIGIT_W-1:0] r_mem [GROUP_LEN];
    logic [DIGIT_W-1:0] r_rd_data;

    // Write the incoming digit
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rtcr_tag_store.sv
// Stored tag memory: ten digits with per-entry valid bits so that an
// entry never written reads as zero. Depends on rtcr_pkg.
module rtcr_tag_store
    import rtcr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mem_req           i_req,
    output logic [DIGIT_W-1:0] o_rd_data
);

    logic [DIGIT_W-1:0]    r_mem [TAG_DIGITS];
    logic [TAG_DIGITS-1:0] r_valid;
    logic [DIGIT_W-1:0]    r_rd_data;

    // Write a digit and mark the entry valid
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Registered read; an invalid entry reads as zero
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rtcr_out_stage.sv
// Output register for result beats and packing onto the master stream.
// Depends on rtcr_pkg.
module rtcr_out_stage
    import rtcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_out_beat             i_beat,
    output logic                  o_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], tag_value[41:2], bit_index[47:42], frame_bit[48],
    // coil_first_half[49], coil_second_half[50], zero pad[55:51]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    logic      r_valid;
    t_out_beat r_beat;
    logic      w_coil_first;
    logic      w_coil_second;

    assign o_free = !r_valid || m_axis_tready;

    // Track occupancy of the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Load the payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_beat <= i_beat;
        end
    end

    // Coil levels: inverse then true, zero in status beats
    assign w_coil_first  = (r_beat.kind == KIND_BIT) && !r_beat.frame_bit;
    assign w_coil_second = (r_beat.kind == KIND_BIT) && r_beat.frame_bit;

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, w_coil_second, w_coil_first, r_beat.frame_bit,
                            r_beat.bit_index, r_beat.tag_value, r_beat.status};
    assign m_axis_tuser  = r_beat.kind;
    assign m_axis_tlast  = r_beat.last;

endmodule

FILE: rtl/rfid_tag_capture_and_replay_unit.sv
// Top level of the tag capture and replay unit: control sequencer, both
// digit memories and the output stage. Depends on rtcr_pkg and all rtcr_ modules.
//
// Reader bytes (tuser 0) are gathered in groups of fourteen; bytes 1..10 are
// each accepted and then compared against the stored digit read from the tag
// memory, all others are only accepted. The fourteenth byte yields one status
// beat: a failed checksum or a repeated tag goes straight to the status state,
// a new tag after a sweep that copies the digits into the tag memory and then
// stops capture for good; later reader bytes are taken and dropped.
// A send item (tuser 1) yields the 64-beat frame of the stored tag, one beat
// per cycle while m_axis_tready stays high, pushed from the send state entered
// on accept; the single output register and the one-digit-ahead tag memory read
// set that pace. s_axis_tready is low while a byte is compared, a tag is copied,
// a status beat waits for the output register or a frame is being sent.
module rfid_tag_capture_and_replay_unit
    import rtcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // rx_byte[7:0]
    input  logic [7:0]            s_axis_tdata,
    // action[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], tag_value[41:2], bit_index[47:42], frame_bit[48],
    // coil_first_half[49], coil_second_half[50], zero pad[55:51]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_captured, n_captured;
    logic [DIGIT_W-1:0] r_c1, n_c1;
    logic [DIGIT_W-1:0] r_c2, n_c2;
    logic               r_ok, n_ok;
    logic               r_eq, n_eq;
    logic [DIGIT_W-1:0] r_digit, n_digit;
    logic [1:0]         r_status, n_status;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic [POS_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_bit_idx, n_bit_idx;
    logic [2:0]         r_sub, n_sub;
    logic [POS_W-1:0]   r_dig, n_dig;
    logic [NIB_W-1:0]   r_nib, n_nib;
    logic [NIB_W-1:0]   r_col, n_col;

    logic               w_in_acc;
    logic [DIGIT_W-1:0] w_digit;
    logic               w_free;
    logic               w_push;
    logic               w_load;
    logic [1:0]         w_sel;
    t_out_beat          w_beat;
    t_mem_req           w_cap_req;
    t_mem_req           w_tag_req;
    logic [DIGIT_W-1:0] w_cap_rd;
    logic [DIGIT_W-1:0] w_tag_rd;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_digit       = to_digit(s_axis_tdata);
    assign w_sel         = 2'(3'd3 - r_sub);

    // Sequencer next state and memory requests
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_captured = r_captured;
        n_c1       = r_c1;
        n_c2       = r_c2;
        n_ok       = r_ok;
        n_eq       = r_eq;
        n_digit    = r_digit;
        n_status   = r_status;
        n_tag      = r_tag;
        n_cnt      = r_cnt;
        n_bit_idx  = r_bit_idx;
        n_sub      = r_sub;
        n_dig      = r_dig;
        n_nib      = r_nib;
        n_col      = r_col;
        w_cap_req  = '0;
        w_tag_req  = '0;
        w_push     = 1'b0;
        w_load     = 1'b0;
        w_beat     = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && s_axis_tuser == ACT_SEND) begin
                    // Fetch the first digit and start the frame
                    w_tag_req.rd_en   = 1'b1;
                    w_tag_req.rd_addr = '0;
                    n_bit_idx         = '0;
                    n_sub             = '0;
                    n_col             = '0;
                    n_state           = S_SEND;
                end else if (w_in_acc && !r_captured) begin
                    // Store the digit of this reader byte
                    w_cap_req.wr_en   = 1'b1;
                    w_cap_req.wr_addr = r_pos;
                    w_cap_req.wr_data = w_digit;
                    n_pos             = r_pos + 4'd1;
                    if (r_pos == POS_FIRST) begin
                        n_c1 = '0;
                        n_c2 = '0;
                        n_ok = 1'b1;
                        n_eq = 1'b1;
                    end else if (r_pos <= POS_DATA_LAST) begin
                        w_tag_req.rd_en   = 1'b1;
                        w_tag_req.rd_addr = r_pos - 4'd1;
                        n_digit           = w_digit;
                        if (r_pos[0]) begin
                            n_c1 = r_c1 ^ w_digit;
                        end else begin
                            n_c2 = r_c2 ^ w_digit;
                        end
                        n_state = S_CMP;
                    end else if (r_pos == POS_CHK_ODD) begin
                        n_ok = r_ok && (w_digit == r_c1);
                    end else if (r_pos == POS_CHK_EVEN) begin
                        n_ok = r_ok && (w_digit == r_c2);
                    end else if (r_pos == POS_LAST) begin
                        // Group complete: decide the status
                        n_pos = POS_FIRST;
                        n_tag = '0;
                        n_cnt = '0;
                        if (!r_ok) begin
                            n_status = STATUS_CK_FAIL;
                            n_state  = S_STAT;
                        end else if (r_eq) begin
                            n_status = STATUS_SAME;
                            n_state  = S_STAT;
                        end else begin
                            n_state = S_COPY;
                        end
                    end
                end
            end

            S_CMP: begin
                // Compare against the stored digit read last cycle
                n_eq    = r_eq && (w_tag_rd == r_digit);
                n_state = S_IDLE;
            end

            S_COPY: begin
                // Read one digit ahead, write the one read last cycle
                if (r_cnt < COPY_END) begin
                    w_cap_req.rd_en   = 1'b1;
                    w_cap_req.rd_addr = r_cnt + 4'd1;
                end
                if (r_cnt != '0) begin
                    w_tag_req.wr_en   = 1'b1;
                    w_tag_req.wr_addr = r_cnt - 4'd1;
                    w_tag_req.wr_data = w_cap_rd;
                    n_tag             = {r_tag[TAG_W-NIB_W-1:0], w_cap_rd[NIB_W-1:0]};
                end
                if (r_cnt == COPY_END) begin
                    n_captured = 1'b1;
                    n_status   = STATUS_NEW;
                    n_state    = S_STAT;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end

            S_STAT: begin
                // Hand the status beat to the output register
                if (w_free) begin
                    w_push           = 1'b1;
                    w_beat.kind      = KIND_STATUS;
                    w_beat.status    = r_status;
                    w_beat.tag_value = r_tag;
                    n_state          = S_IDLE;
                end
            end

            S_SEND: begin
                if (w_free) begin
                    w_push           = 1'b1;
                    w_beat.kind      = KIND_BIT;
                    w_beat.bit_index = r_bit_idx;
                    w_beat.last      = (r_bit_idx == BIT_STOP);
                    n_bit_idx        = r_bit_idx + 6'd1;
                    if (r_bit_idx < BIT_DATA_START) begin
                        // Header ones; load the first digit on the last of them
                        w_beat.frame_bit = 1'b1;
                        if (r_bit_idx == BIT_PRE_LAST) begin
                            w_load = 1'b1;
                            n_dig  = '0;
                        end
                    end else if (r_bit_idx < BIT_COL_START) begin
                        // Digit bits, most significant first, then row parity
                        if (r_sub == SUB_PARITY) begin
                            w_beat.frame_bit = ^r_nib;
                            n_sub            = '0;
                            if (r_dig < DIGIT_LAST) begin
                                w_load = 1'b1;
                                n_dig  = r_dig + 4'd1;
                            end
                        end else begin
                            w_beat.frame_bit = r_nib[w_sel];
                            n_sub            = r_sub + 3'd1;
                        end
                    end else if (r_bit_idx < BIT_STOP) begin
                        // Column parities, bit 3 first
                        w_beat.frame_bit = r_col[NIB_W-1];
                        n_col            = {r_col[NIB_W-2:0], 1'b0};
                    end else begin
                        w_beat.frame_bit = 1'b0;
                        n_state          = S_IDLE;
                    end

                    // Take the prefetched digit and fetch the next one
                    if (w_load) begin
                        n_nib = w_tag_rd[NIB_W-1:0];
                        n_col = r_col ^ w_tag_rd[NIB_W-1:0];
                        if (n_dig < DIGIT_LAST) begin
                            w_tag_req.rd_en   = 1'b1;
                            w_tag_req.rd_addr = n_dig + 4'd1;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_captured <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_captured <= n_captured;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_c1      <= n_c1;
        r_c2      <= n_c2;
        r_ok      <= n_ok;
        r_eq      <= n_eq;
        r_digit   <= n_digit;
        r_status  <= n_status;
        r_tag     <= n_tag;
        r_cnt     <= n_cnt;
        r_bit_idx <= n_bit_idx;
        r_sub     <= n_sub;
        r_dig     <= n_dig;
        r_nib     <= n_nib;
        r_col     <= n_col;
    end

    rtcr_digit_ram u_digit_ram (
        .i_clk     (i_clk),
        .i_req     (w_cap_req),
        .o_rd_data (w_cap_rd)
    );

    rtcr_tag_store u_tag_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_tag_req),
        .o_rd_data (w_tag_rd)
    );

    rtcr_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_beat        (w_beat),
        .o_free        (w_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Capture, once done, stays done
    a_captured_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_captured |=> r_captured)
        else $error("capture flag cleared");

    // The tag memory is written only by the copy sweep
    a_tag_write_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tag_req.wr_en |-> (r_state == S_COPY))
        else $error("tag memory written outside copy sweep");

    // A beat marked last is the stop bit of a frame
    a_last_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser == KIND_BIT && m_axis_tdata[47:42] == BIT_STOP))
        else $error("last beat is not frame bit 63");

    // The frame position holds while the output is stalled
    a_send_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND && !w_free) |=> $stable(r_bit_idx))
        else $error("frame position moved without a beat");

endmodule

FILE: dv/tag_replay_sb_pkg.sv
// Scoreboard for the tag capture and replay unit: a predictor of the capture
// groups and frame replays, plus the queue of beats it expects on the output.
// Depends on rtcr_pkg for field widths and codes.
package tag_replay_sb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import rtcr_pkg::*;

    localparam int FRAME_BITS = 64;

    // Field positions of m_axis_tdata
    localparam int STATUS_LSB  = 0;
    localparam int TAG_LSB     = 2;
    localparam int INDEX_LSB   = 42;
    localparam int BIT_POS     = 48;
    localparam int COIL_A_POS  = 49;
    localparam int COIL_B_POS  = 50;

    typedef struct {
        logic             kind;
        logic [1:0]       status;
        logic [TAG_W-1:0] tag_value;
        logic [IDX_W-1:0] bit_index;
        logic             frame_bit;
        logic             coil_first;
        logic             coil_second;
        logic             last;
    } t_tag_beat;

    // Digit value of a reader byte: decimal characters map to 0..9, all
    // other bytes are offset as upper-case hex letters, wrapping at 256
    function automatic logic [DIGIT_W-1:0] ascii_digit(input logic [7:0] b);
        if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
            return b - ASCII_ZERO;
        end
        return b - ALPHA_OFFSET;
    endfunction

    // Byte that yields the given digit, or -1 where no byte does
    function automatic int byte_for_digit(input logic [DIGIT_W-1:0] d);
        int b;
        for (b = 0; b < 256; b++) begin
            if (ascii_digit(b[7:0]) == d) begin
                return b;
            end
        end
        return -1;
    endfunction

    class tag_replay_scoreboard;
        int unsigned        mismatches;
        int unsigned        byte_pos;
        logic [DIGIT_W-1:0] group_digits[GROUP_LEN];
        logic [DIGIT_W-1:0] saved_tag[TAG_DIGITS];
        bit                 captured;
        t_tag_beat          expected_beats[$];

        function new();
            mismatches = 0;
            byte_pos   = 0;
            captured   = 1'b0;
            foreach (group_digits[k]) group_digits[k] = '0;
            foreach (saved_tag[k]) saved_tag[k] = '0;
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

        // Queue the frame of the stored tag, one beat per bit
        function void queue_frame();
            logic [FRAME_BITS-1:0] frame;
            logic [NIB_W-1:0]      nib;
            logic                  col;
            t_tag_beat             beat;
            frame = '0;
            for (int p = 0; p <= BIT_PRE_LAST; p++) frame[p] = 1'b1;
            for (int i = 0; i < TAG_DIGITS; i++) begin
                nib = saved_tag[i][NIB_W-1:0];
                for (int b = 0; b < NIB_W; b++) begin
                    frame[BIT_DATA_START + 5 * i + 3 - b] = nib[b];
                end
                frame[BIT_DATA_START + 5 * i + 4] = ^nib;
            end
            // column parities, digit bit 3 first
            for (int b = 0; b < NIB_W; b++) begin
                col = 1'b0;
                for (int i = 0; i < TAG_DIGITS; i++) col ^= saved_tag[i][b];
                frame[BIT_STOP - 1 - b] = col;
            end
            frame[BIT_STOP] = 1'b0;
            for (int k = 0; k < FRAME_BITS; k++) begin
                beat.kind        = KIND_BIT;
                beat.status      = '0;
                beat.tag_value   = '0;
                beat.bit_index   = k[IDX_W-1:0];
                beat.frame_bit   = frame[k];
                beat.coil_first  = ~frame[k];
                beat.coil_second = frame[k];
                beat.last        = (k == FRAME_BITS - 1);
                expected_beats.push_back(beat);
            end
        endfunction

        // Gather a group of reader bytes and judge it on the fourteenth
        function void take_reader_byte(logic [7:0] rx);
            logic [DIGIT_W-1:0] odd_sum;
            logic [DIGIT_W-1:0] even_sum;
            t_tag_beat          beat;
            bit                 same;
            if (captured) return;
            group_digits[byte_pos] = ascii_digit(rx);
            byte_pos++;
            if (byte_pos < GROUP_LEN) return;
            byte_pos = 0;

            odd_sum  = '0;
            even_sum = '0;
            for (int k = 1; k <= TAG_DIGITS; k++) begin
                if (k % 2 == 1) odd_sum ^= group_digits[k];
                else            even_sum ^= group_digits[k];
            end
            beat = '{default: '0};
            beat.kind = KIND_STATUS;
            if (odd_sum != group_digits[POS_CHK_ODD] ||
                even_sum != group_digits[POS_CHK_EVEN]) begin
                beat.status = STATUS_CK_FAIL;
            end else begin
                same = 1'b1;
                for (int i = 0; i < TAG_DIGITS; i++) begin
                    if (group_digits[i + 1] != saved_tag[i]) same = 1'b0;
                end
                if (same) begin
                    beat.status = STATUS_SAME;
                end else begin
                    // take the new tag and stop capturing
                    beat.status = STATUS_NEW;
                    captured    = 1'b1;
                    for (int i = 0; i < TAG_DIGITS; i++) begin
                        saved_tag[i]   = group_digits[i + 1];
                        beat.tag_value = {beat.tag_value[TAG_W-NIB_W-1:0],
                                          saved_tag[i][NIB_W-1:0]};
                    end
                end
            end
            expected_beats.push_back(beat);
        endfunction

        // Note one accepted input beat
        function void note_input(logic action, logic [7:0] rx);
            if (action == ACT_SEND) queue_frame();
            else take_reader_byte(rx);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        // Check one accepted output beat against the oldest expectation
        function void check_beat(logic [OUT_DATA_W-1:0] tdata, logic tuser, logic tlast);
            t_tag_beat want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected beat, expected none, actual tdata 0x%0h %s%0b",
                         $time, tdata, "tuser ", tuser);
                return;
            end
            want = expected_beats.pop_front();
            check_field("kind", want.kind, tuser);
            check_field("status", want.status, tdata[STATUS_LSB +: 2]);
            check_field("tag_value", want.tag_value, tdata[TAG_LSB +: TAG_W]);
            check_field("bit_index", want.bit_index, tdata[INDEX_LSB +: IDX_W]);
            check_field("frame_bit", want.frame_bit, tdata[BIT_POS]);
            check_field("coil_first_half", want.coil_first, tdata[COIL_A_POS]);
            check_field("coil_second_half", want.coil_second, tdata[COIL_B_POS]);
            check_field("last", want.last, tlast);
        endfunction
    endclass

endpackage

FILE: dv/tb_rfid_tag_capture_and_replay_unit.sv
// Testbench top for rfid_tag_capture_and_replay_unit: drives reader bytes and
// frame replays with bursty input and a stalling sink, checks every output beat.
// Depends on rtcr_pkg and tag_replay_sb_pkg.
module tb_rfid_tag_capture_and_replay_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rtcr_pkg::*;
    import tag_replay_sb_pkg::*;

    localparam int RST_CYCLES   = 7;
    localparam int PRE_GROUPS   = 25;
    localparam int POST_ITEMS   = 24;
    localparam int SEND_ODDS    = 16;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] WIDE_LO       = 8'h47;
    localparam logic [7:0] WIDE_HI       = 8'hC8;

    typedef enum int {
        GRP_ZERO_TAG,
        GRP_BAD_SUM,
        GRP_NOISE,
        GRP_GOOD_TAG
    } t_group_kind;

    typedef enum int {
        RX_READY,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SLOW
    } t_rx_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    tag_replay_scoreboard tag_sb = new();

    logic [7:0] group_bytes[GROUP_LEN];
    int         burst_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rfid_tag_capture_and_replay_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Sink back-pressure: switch between stall patterns every so often
    t_rx_mode rx_mode       = RX_READY;
    int       rx_phase_left = 0;
    int       rx_tick       = 0;

    always @(negedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = t_rx_mode'($urandom_range(3));
            rx_phase_left = $urandom_range(20, 150);
        end
        rx_phase_left--;
        rx_tick++;
        case (rx_mode)
            RX_READY:    m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(3) != 0);
            RX_PERIODIC: m_axis_tready <= (rx_tick % 3 != 0);
            default:     m_axis_tready <= ($urandom_range(9) < 3);
        endcase
    end

    // Check each output beat as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tag_sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Offer one beat, inserting a random gap at the start of each burst
    task automatic put_item(input logic action, input logic [7:0] rx);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = action;
        s_axis_tdata  = rx;
        do @(posedge i_clk); while (!s_axis_tready);
        tag_sb.note_input(action, rx);
    endtask

    // Hold the input idle until every expected beat has arrived
    task automatic pause_until_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tag_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Play the current group, with replays slipped in between its bytes
    task automatic play_group(input int send_odds);
        int k;
        for (k = 0; k < GROUP_LEN; k++) begin
            if (send_odds != 0 && $urandom_range(send_odds - 1) == 0) begin
                put_item(ACT_SEND, 8'($urandom));
            end
            put_item(ACT_BYTE, group_bytes[k]);
        end
    endtask

    function automatic logic [7:0] pick_digit_byte();
        case ($urandom_range(3))
            0, 1:    return 8'(ASCII_ZERO + $urandom_range(9));
            2:       return 8'(ASCII_UPPER_A + $urandom_range(5));
            default: return 8'($urandom);
        endcase
    endfunction

    // Fill group_bytes with a group of the given kind
    function automatic void build_group(input t_group_kind kind);
        logic [DIGIT_W-1:0] odd_sum;
        logic [DIGIT_W-1:0] even_sum;
        logic [7:0]         wrong;
        int                 b_odd;
        int                 b_even;
        int                 k;
        int                 which;
        case (kind)
            GRP_NOISE: begin
                for (k = 0; k < GROUP_LEN; k++) group_bytes[k] = 8'($urandom);
            end
            GRP_ZERO_TAG: begin
                // zero digits, so the checksums are zero too
                group_bytes[POS_FIRST] = 8'($urandom);
                for (k = 1; k <= POS_CHK_EVEN; k++) begin
                    group_bytes[k] = ASCII_ZERO;
                end
                group_bytes[POS_LAST] = 8'($urandom);
            end
            default: begin
                do begin
                    group_bytes[POS_FIRST] = 8'($urandom);
                    group_bytes[POS_LAST]  = 8'($urandom);
                    for (k = 1; k <= TAG_DIGITS; k++) group_bytes[k] = pick_digit_byte();
                    // a captured tag always carries a digit above fifteen
                    if (kind == GRP_GOOD_TAG) begin
                        group_bytes[$urandom_range(1, TAG_DIGITS)] =
                            8'($urandom_range(WIDE_LO, WIDE_HI));
                    end
                    odd_sum  = '0;
                    even_sum = '0;
                    for (k = 1; k <= TAG_DIGITS; k++) begin
                        if (k % 2 == 1) odd_sum ^= ascii_digit(group_bytes[k]);
                        else            even_sum ^= ascii_digit(group_bytes[k]);
                    end
                    b_odd  = byte_for_digit(odd_sum);
                    b_even = byte_for_digit(even_sum);
                end while (b_odd < 0 || b_even < 0);
                group_bytes[POS_CHK_ODD]  = b_odd[7:0];
                group_bytes[POS_CHK_EVEN] = b_even[7:0];
                // spoil one or both checksum bytes
                if (kind == GRP_BAD_SUM) begin
                    which = $urandom_range(2);
                    for (k = POS_CHK_ODD; k <= POS_CHK_EVEN; k++) begin
                        if (which == 2 || which == k - POS_CHK_ODD) begin
                            do wrong = 8'($urandom);
                            while (ascii_digit(wrong) == ascii_digit(group_bytes[k]));
                            group_bytes[k] = wrong;
                        end
                    end
                end
            end
        endcase
    endfunction

    initial begin
        int k;
        int pick;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Replay of the all-zero tag, a repeated zero tag with extreme bytes, then a second replay
        put_item(ACT_SEND, 8'h00);
        group_bytes[POS_FIRST] = 8'h00;
        for (k = 1; k <= POS_CHK_EVEN; k++) begin
            group_bytes[k] = ASCII_ZERO;
        end
        group_bytes[POS_LAST] = 8'hFF;
        play_group(0);
        put_item(ACT_SEND, 8'hFF);
        pause_until_drained();

        // Groups that fail the checksum or repeat the stored tag
        repeat (PRE_GROUPS) begin
            pick = $urandom_range(9);
            if (pick < 4)      build_group(GRP_ZERO_TAG);
            else if (pick < 8) build_group(GRP_BAD_SUM);
            else               build_group(GRP_NOISE);
            play_group(SEND_ODDS);
        end
        pause_until_drained();

        // Capture a new tag, then replay it among bytes that are dropped
        build_group(GRP_GOOD_TAG);
        play_group(0);
        pause_until_drained();
        put_item(ACT_SEND, 8'($urandom));
        repeat (POST_ITEMS) begin
            put_item($urandom_range(1) ? ACT_SEND : ACT_BYTE, 8'($urandom));
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tag_sb.mismatches == 0 && tag_sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rtcr_pkg.sv
rtl/rtcr_digit_ram.sv
rtl/rtcr_tag_store.sv
rtl/rtcr_out_stage.sv
rtl/rfid_tag_capture_and_replay_unit.sv
dv/tag_replay_sb_pkg.sv
dv/tb_rfid_tag_capture_and_replay_unit.sv
